// ----- hdl/mdmt_pkg.sv -----
package mdmt_pkg;

  localparam logic [15:0] TOP_BYTE_MASK = 16'hFF00;

  localparam logic [2:0] CMD_REG_EXACT = 3'd0;
  localparam logic [2:0] CMD_REG_CAT   = 3'd1;
  localparam logic [2:0] CMD_UNREG     = 3'd2;
  localparam logic [2:0] CMD_CLEAR     = 3'd3;
  localparam logic [2:0] CMD_LOOKUP    = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_INVALID   = 3'd1;
  localparam logic [2:0] STATUS_DENIED    = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_EXISTS    = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_EXACT    = 2'd1;
  localparam logic [1:0] KIND_CATEGORY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic [15:0] mtype;
    logic        is_cat;
    logic [7:0]  handler;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic live;
    logic compare;
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic ex_hit;
    logic cat_same;
    logic cat_hit;
    logic hid_eq;
  } cell_flags_t;

endpackage

// ----- hdl/mdmt_cell.sv -----
module mdmt_cell import mdmt_pkg::*; (
  input  logic        clk,
  input  cell_ctl_t   ctl,
  input  logic [15:0] key,
  input  logic [7:0]  key_hid,
  input  entry_t      new_entry,
  input  entry_t      next_entry,
  output entry_t      entry,
  output cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= new_entry;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end
  end

  // compare results are captured on the input transfer
  always_ff @(posedge clk) begin
    if (ctl.compare) begin
      flags.ex_hit   <= ctl.live && !entry.is_cat && (entry.mtype == key);
      flags.cat_same <= ctl.live && entry.is_cat && (entry.mtype == key);
      flags.cat_hit  <= ctl.live && entry.is_cat &&
                        ((entry.mtype & TOP_BYTE_MASK) == (key & TOP_BYTE_MASK));
      flags.hid_eq   <= (entry.handler == key_hid);
    end
  end

endmodule

// ----- hdl/message_dispatch_match_table_unit.sv -----
// Message dispatch match table: an ordered list of exact and category
// entries mapping message types to handler ids.
// Input channel (in_valid/in_stall) carries one command per transfer:
// register exact, register category, unregister, clear or lookup.
// Output channel (out_valid/out_stall) returns exactly one result per command.
// cfg_we/cfg_wdata write module_ident; write it only while the block is idle.
// Each cell compares its entry against the type on the input transfer edge;
// in the evaluate state a first-hit pick over the registered cell flags
// produces the result and updates the row (append at the tail, or every cell
// at and above the removed entry takes its upper neighbor). The result and
// out_valid are registered when the evaluate state completes; in_stall is high
// while a command is in evaluation, so a new command is taken only after the
// previous one has left the evaluate state.
// A stalled result waits in the output register while the next command is
// taken; that command then keeps in_stall high until the receiver takes the
// earlier result. Results are never dropped.
// Synchronous reset empties the table and clears module_ident.
module message_dispatch_match_table_unit import mdmt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [15:0] message_type,
  input  logic [7:0]  handler_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  matched_handler,
  output logic [1:0]  match_kind
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t            state, state_next;
  logic [15:0]       module_ident;
  logic [CW-1:0]     count, count_next;
  logic [2:0]        cmd_q;
  logic [15:0]       type_q;
  logic [7:0]        hid_q;
  logic [2:0]        status_next;
  logic [7:0]        handler_next;
  logic [1:0]        kind_next;
  logic              accept, fire, append, remove;

  entry_t            entries [TABLE_DEPTH];
  entry_t            new_entry;
  logic [TABLE_DEPTH-1:0] ex_v, cat_same_v, cat_hit_v, hid_eq_v;
  logic [TABLE_DEPTH-1:0] first_ex, first_cat, dup_v, first_dup, shift_mask;
  logic [7:0]        ex_handler, cat_handler;
  logic              full, dup_same;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign fire = (state == S_EVAL) && (!out_valid || !out_stall);

  assign new_entry.mtype   = type_q;
  assign new_entry.is_cat  = (cmd_q == CMD_REG_CAT);
  assign new_entry.handler = hid_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t   ctl;
    cell_flags_t flags;
    entry_t      next_entry;

    assign ctl.live    = (count > CW'(i));
    assign ctl.compare = accept;
    assign ctl.load    = fire && append && (count == CW'(i));
    assign ctl.shift   = fire && remove && shift_mask[i];

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    mdmt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (message_type),
      .key_hid    (handler_id),
      .new_entry  (new_entry),
      .next_entry (next_entry),
      .entry      (entries[i]),
      .flags      (flags)
    );

    assign ex_v[i]       = flags.ex_hit;
    assign cat_same_v[i] = flags.cat_same;
    assign cat_hit_v[i]  = flags.cat_hit;
    assign hid_eq_v[i]   = flags.hid_eq;
  end

  // isolate the lowest set bit: first hit in list order
  assign first_ex   = ex_v & (~ex_v + TABLE_DEPTH'(1));
  assign first_cat  = cat_hit_v & (~cat_hit_v + TABLE_DEPTH'(1));
  assign dup_v      = (cmd_q == CMD_REG_CAT) ? cat_same_v : ex_v;
  assign first_dup  = dup_v & (~dup_v + TABLE_DEPTH'(1));
  assign dup_same   = |(first_dup & hid_eq_v);
  // removed entry and everything above it
  assign shift_mask = ex_v | (~ex_v + TABLE_DEPTH'(1));
  assign full       = (count == CW'(TABLE_DEPTH));

  always_comb begin
    ex_handler  = 8'd0;
    cat_handler = 8'd0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ex_handler  = ex_handler | (entries[i].handler & {8{first_ex[i]}});
      cat_handler = cat_handler | (entries[i].handler & {8{first_cat[i]}});
    end
  end

  always_comb begin
    state_next   = state;
    status_next  = STATUS_OK;
    handler_next = 8'd0;
    kind_next    = KIND_NONE;
    count_next   = count;
    append       = 1'b0;
    remove       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (fire) state_next = S_IDLE;
        case (cmd_q)
          CMD_REG_EXACT, CMD_REG_CAT: begin
            if (hid_q == 8'd0) begin
              status_next = STATUS_INVALID;
            end else if (cmd_q == CMD_REG_EXACT && module_ident == 16'd0) begin
              status_next = STATUS_DENIED;
            end else if (cmd_q == CMD_REG_EXACT && type_q == 16'd0) begin
              status_next = STATUS_INVALID;
            end else if (full) begin
              status_next = STATUS_FULL;
            end else if (|dup_v) begin
              status_next = dup_same ? STATUS_OK : STATUS_EXISTS;
            end else begin
              append     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          CMD_UNREG: begin
            if (|ex_v) begin
              remove     = 1'b1;
              count_next = count - CW'(1);
            end else begin
              status_next = STATUS_NOT_FOUND;
            end
          end
          CMD_CLEAR: begin
            count_next = '0;
          end
          CMD_LOOKUP: begin
            if (|ex_v) begin
              handler_next = ex_handler;
              kind_next    = KIND_EXACT;
            end else if (|cat_hit_v) begin
              handler_next = cat_handler;
              kind_next    = KIND_CATEGORY;
            end
          end
          default: begin
            status_next = STATUS_INVALID;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      module_ident <= 16'd0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) module_ident <= cfg_wdata;
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      type_q <= message_type;
      hid_q  <= handler_id;
    end
    if (fire) begin
      status          <= status_next;
      matched_handler <= handler_next;
      match_kind      <= kind_next;
    end
  end

endmodule
